// File: rtl/core/mlal_pkg.sv
// ---------------------------------------------------------------------------
// mlal_pkg: shared definitions for the layered loop recorder
// Item codes, looper states, controller states, datapath command struct and
// fixed widths of the sample path.
// ---------------------------------------------------------------------------
package mlal_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int GAIN_W          = 16;
   localparam int SEL_W           = 3;
   localparam int MODE_W          = 3;
   localparam int DEF_MAX_LAYERS  = 4;
   localparam int DEF_MAX_FRAMES  = 65536;
   localparam int ROUND_SHIFT     = 14;
   localparam int ROUND_BIAS      = 8192;
   // product is signed sample times unsigned gain, sum of up to nine terms
   localparam int PROD_W          = SAMPLE_BITS + GAIN_W + 1;
   localparam int ACC_W           = PROD_W + 4;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd16384;
   localparam logic [SEL_W-1:0]  NO_LAYER   = 3'd7;

   typedef enum logic [MODE_W-1:0] {
      MODE_SAMPLE  = 3'd0,
      MODE_RECORD  = 3'd1,
      MODE_STOP    = 3'd2,
      MODE_OVERDUB = 3'd3,
      MODE_UNDO    = 3'd4,
      MODE_GAIN    = 3'd5,
      MODE_MUTE    = 3'd6,
      MODE_NOP     = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      RUN_IDLE = 2'd0,
      RUN_REC  = 2'd1,
      RUN_PLAY = 2'd2,
      RUN_OVD  = 2'd3
   } run_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_CMD,
      CS_MIX,
      CS_DRAIN0,
      CS_DRAIN1,
      CS_FIN
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic commit_cmd;
      logic commit_smp;
   } dp_cmd_type;

endpackage

// File: rtl/core/mlal_ram.sv
// ---------------------------------------------------------------------------
// mlal_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module mlal_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/mlal_ctrl.sv
// ---------------------------------------------------------------------------
// mlal_ctrl: item sequencer
// Accepts items, steps the layer reads of a sample through the datapath and
// commits results into the response register when it is free.
// ---------------------------------------------------------------------------
module mlal_ctrl #(
   parameter int MAX_LAYERS = mlal_pkg::DEF_MAX_LAYERS,
   localparam int LB = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mlal_pkg::MODE_W-1:0]         req_mode,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mlal_pkg::dp_cmd_type                cmd,
   output logic [LB-1:0]                       mix_idx
);

   mlal_pkg::ctrl_state_type state_ff, state_in;
   logic [LB-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlal_pkg::CS_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mlal_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            idx_in    = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_mode == mlal_pkg::MODE_SAMPLE) ? mlal_pkg::CS_MIX
                                                              : mlal_pkg::CS_CMD;
            end
         end
         mlal_pkg::CS_CMD: begin
            if (out_free) begin
               cmd.commit_cmd = 1'b1;
               state_in       = mlal_pkg::CS_IDLE;
            end
         end
         mlal_pkg::CS_MIX: begin
            cmd.issue = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LB'(MAX_LAYERS - 1)) begin
               state_in = mlal_pkg::CS_DRAIN0;
            end
         end
         mlal_pkg::CS_DRAIN0: state_in = mlal_pkg::CS_DRAIN1;
         mlal_pkg::CS_DRAIN1: state_in = mlal_pkg::CS_FIN;
         mlal_pkg::CS_FIN: begin
            if (out_free) begin
               cmd.commit_smp = 1'b1;
               state_in       = mlal_pkg::CS_IDLE;
            end
         end
         default: state_in = mlal_pkg::CS_IDLE;
      endcase
   end

   assign commit       = cmd.commit_cmd || cmd.commit_smp;
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign mix_idx      = idx_ff;

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlal_pkg::CS_IDLE && req_valid) |=>
      (state_ff == mlal_pkg::CS_MIX || state_ff == mlal_pkg::CS_CMD))
      else $error("accepted item not dispatched");

   a_drain_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlal_pkg::CS_DRAIN1) |=> (state_ff == mlal_pkg::CS_FIN))
      else $error("mix pipeline drain out of order");

   a_no_commit_over_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !commit)
      else $error("result overwritten while pending");

endmodule

// File: rtl/core/mlal_dp.sv
// ---------------------------------------------------------------------------
// mlal_dp: looper datapath
// Layer state, sample store, multiply-accumulate mix, rounding, saturation,
// peak hold and the response register.
// ---------------------------------------------------------------------------
module mlal_dp #(
   parameter int MAX_LAYERS = mlal_pkg::DEF_MAX_LAYERS,
   parameter int MAX_FRAMES = mlal_pkg::DEF_MAX_FRAMES,
   localparam int LB = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mlal_pkg::dp_cmd_type                     cmd,
   input  logic [LB-1:0]                            mix_idx,
   input  logic [mlal_pkg::MODE_W-1:0]              req_mode,
   input  logic signed [mlal_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   input  logic [mlal_pkg::SEL_W-1:0]               req_layer_sel,
   input  logic [mlal_pkg::GAIN_W-1:0]              req_gain_value,
   input  logic                                     req_mute_value,
   output logic signed [mlal_pkg::SAMPLE_BITS-1:0]  rsp_sample_out,
   output logic [mlal_pkg::SAMPLE_BITS-1:0]         rsp_peak_out,
   output logic [1:0]                               rsp_looper_mode,
   output logic [2:0]                               rsp_layers_used
);

   localparam int SB     = mlal_pkg::SAMPLE_BITS;
   localparam int GW     = mlal_pkg::GAIN_W;
   localparam int AW_ACC = mlal_pkg::ACC_W;
   localparam int FB     = $clog2(MAX_FRAMES);
   localparam int PW     = $clog2(MAX_FRAMES + 1);
   localparam int TW     = $clog2(MAX_LAYERS + 1);
   localparam int RAW    = LB + FB;
   localparam int DEPTH  = MAX_LAYERS * (2 ** FB);
   localparam int YW     = AW_ACC - mlal_pkg::ROUND_SHIFT;
   localparam logic signed [YW-1:0] Y_HI = YW'((2 ** (SB - 1)) - 1);
   localparam logic signed [YW-1:0] Y_LO = -Y_HI - YW'(1);

   // latched item
   mlal_pkg::mode_type      mode_ff;
   logic signed [SB-1:0]    smp_ff;
   logic [mlal_pkg::SEL_W-1:0] sel_ff;
   logic [GW-1:0]           gval_ff;
   logic                    mval_ff;

   // looper state
   logic [PW-1:0]    len_ff  [MAX_LAYERS], len_in  [MAX_LAYERS];
   logic [PW-1:0]    ext_ff  [MAX_LAYERS], ext_in  [MAX_LAYERS];
   logic [GW-1:0]    gain_ff [MAX_LAYERS], gain_in [MAX_LAYERS];
   logic             mute_ff [MAX_LAYERS], mute_in [MAX_LAYERS];
   logic [PW-1:0]    loop_len_ff, loop_len_in;
   logic [PW-1:0]    pos_ff, pos_in;
   mlal_pkg::run_type run_ff, run_in;
   logic [TW-1:0]    total_ff, total_in;
   logic [mlal_pkg::SEL_W-1:0] active_ff, active_in;
   logic [SB-1:0]    peak_ff, peak_in;

   // mix pipeline
   logic                    s1_valid_ff;
   logic [GW-1:0]           s1_gain_ff;
   logic                    p_valid_ff;
   logic signed [mlal_pkg::PROD_W-1:0] p_ff;
   logic signed [AW_ACC-1:0] acc_ff, acc_in;

   // response register
   logic signed [SB-1:0] rsp_smp_ff;
   logic [SB-1:0]        rsp_peak_ff;
   logic [1:0]           rsp_mode_ff;
   logic [2:0]           rsp_layers_ff;

   logic [3:0]           idx4, lim4, act4, total4, sel4;
   logic                 incl;
   logic signed [SB-1:0] rd_data;
   logic                 we;
   logic [RAW-1:0]       raddr, waddr;
   logic [PW:0]          pos_inc;
   logic signed [AW_ACC-1:0] rnd;
   logic signed [YW-1:0] y_full;
   logic signed [SB-1:0] y;
   logic signed [SB:0]   y_ext, mag_wide;
   logic [SB-1:0]        mag, peak_smp;

   mlal_ram #(
      .WIDTH  (SB),
      .DEPTH  (DEPTH),
      .ADDR_W (RAW)
   ) u_store (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (smp_ff),
      .rd_addr (raddr),
      .rd_data (rd_data)
   );

   assign idx4   = 4'(mix_idx);
   assign act4   = 4'(active_ff);
   assign total4 = 4'(total_ff);
   assign sel4   = 4'(sel_ff);

   // layer inclusion for the read being issued
   always_comb begin
      unique case (run_ff)
         mlal_pkg::RUN_REC:  lim4 = act4;
         mlal_pkg::RUN_PLAY: lim4 = total4;
         mlal_pkg::RUN_OVD:  lim4 = total4;
         default:            lim4 = 4'd0;
      endcase
      incl = (idx4 < lim4)
           && !(run_ff == mlal_pkg::RUN_OVD && act4 == idx4)
           && !mute_ff[mix_idx]
           && (pos_ff < len_ff[mix_idx])
           && (pos_ff < ext_ff[mix_idx])
           && (pos_ff < PW'(MAX_FRAMES));
   end

   assign raddr = {mix_idx, pos_ff[FB-1:0]};
   assign waddr = {active_ff[LB-1:0], pos_ff[FB-1:0]};

   always_comb begin
      if (cmd.load) begin
         acc_in = AW_ACC'(req_sample_in) <<< mlal_pkg::ROUND_SHIFT;
      end else if (p_valid_ff) begin
         acc_in = acc_ff + AW_ACC'(p_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // round to nearest, saturate, magnitude for the peak hold
   always_comb begin
      rnd    = acc_ff + AW_ACC'(mlal_pkg::ROUND_BIAS);
      y_full = YW'(rnd >>> mlal_pkg::ROUND_SHIFT);
      priority if (y_full > Y_HI) begin
         y = SB'(Y_HI);
      end else if (y_full < Y_LO) begin
         y = SB'(Y_LO);
      end else begin
         y = SB'(y_full);
      end
      y_ext    = {y[SB-1], y};
      mag_wide = y_ext[SB] ? -y_ext : y_ext;
      mag      = mag_wide[SB-1:0];
      peak_smp = (mag > peak_ff) ? mag : peak_ff;
   end

   assign we = cmd.commit_smp
            && (run_ff == mlal_pkg::RUN_REC
                || (run_ff == mlal_pkg::RUN_OVD && pos_ff < loop_len_ff))
            && (act4 < 4'(MAX_LAYERS))
            && (pos_ff < PW'(MAX_FRAMES));

   assign pos_inc = {1'b0, pos_ff} + 1'b1;

   // next looper state
   always_comb begin
      len_in      = len_ff;
      ext_in      = ext_ff;
      gain_in     = gain_ff;
      mute_in     = mute_ff;
      loop_len_in = loop_len_ff;
      pos_in      = pos_ff;
      run_in      = run_ff;
      total_in    = total_ff;
      active_in   = active_ff;
      peak_in     = peak_ff;
      if (cmd.commit_smp) begin
         peak_in = peak_smp;
         for (int i = 0; i < MAX_LAYERS; i++) begin
            if (we && act4 == 4'(i) && pos_inc > (PW + 1)'(ext_ff[i])) begin
               ext_in[i] = PW'(pos_inc);
            end
         end
         unique case (run_ff)
            mlal_pkg::RUN_REC: begin
               if (pos_ff < PW'(MAX_FRAMES)) begin
                  pos_in = PW'(pos_inc);
               end
            end
            mlal_pkg::RUN_PLAY, mlal_pkg::RUN_OVD: begin
               if (loop_len_ff != '0) begin
                  pos_in = (pos_inc >= (PW + 1)'(loop_len_ff)) ? '0 : PW'(pos_inc);
               end else if (pos_ff < PW'(MAX_FRAMES)) begin
                  pos_in = PW'(pos_inc);
               end
            end
            default: ;
         endcase
      end else if (cmd.commit_cmd) begin
         unique case (mode_ff)
            mlal_pkg::MODE_RECORD, mlal_pkg::MODE_OVERDUB: begin
               if (total4 < 4'(MAX_LAYERS)
                   && (mode_ff == mlal_pkg::MODE_RECORD || loop_len_ff != '0)) begin
                  for (int i = 0; i < MAX_LAYERS; i++) begin
                     if (total4 == 4'(i)) begin
                        len_in[i]  = (mode_ff == mlal_pkg::MODE_RECORD) ? '0 : loop_len_ff;
                        ext_in[i]  = '0;
                        gain_in[i] = mlal_pkg::UNITY_GAIN;
                        mute_in[i] = 1'b0;
                     end
                  end
                  total_in  = total_ff + 1'b1;
                  active_in = 3'(total_ff);
                  pos_in    = '0;
                  run_in    = (mode_ff == mlal_pkg::MODE_RECORD) ? mlal_pkg::RUN_REC
                                                                 : mlal_pkg::RUN_OVD;
               end
            end
            mlal_pkg::MODE_STOP: begin
               priority if (run_ff == mlal_pkg::RUN_REC && act4 < 4'(MAX_LAYERS)) begin
                  for (int i = 0; i < MAX_LAYERS; i++) begin
                     if (act4 == 4'(i)) begin
                        len_in[i] = pos_ff;
                     end
                  end
                  if (loop_len_ff == '0) begin
                     loop_len_in = pos_ff;
                  end
                  run_in = mlal_pkg::RUN_PLAY;
                  pos_in = '0;
               end else if (run_ff == mlal_pkg::RUN_OVD) begin
                  run_in = mlal_pkg::RUN_PLAY;
               end else begin
                  run_in = mlal_pkg::RUN_IDLE;
               end
            end
            mlal_pkg::MODE_UNDO: begin
               if (total_ff != '0) begin
                  total_in = total_ff - 1'b1;
                  pos_in   = '0;
                  if (total_ff == TW'(1)) begin
                     run_in      = mlal_pkg::RUN_IDLE;
                     loop_len_in = '0;
                  end else begin
                     run_in = mlal_pkg::RUN_PLAY;
                  end
               end
            end
            mlal_pkg::MODE_GAIN, mlal_pkg::MODE_MUTE: begin
               for (int i = 0; i < MAX_LAYERS; i++) begin
                  if (sel4 < total4 && sel4 == 4'(i)) begin
                     if (mode_ff == mlal_pkg::MODE_GAIN) begin
                        gain_in[i] = gval_ff;
                     end else begin
                        mute_in[i] = mval_ff;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LAYERS; i++) begin
            len_ff[i]  <= '0;
            ext_ff[i]  <= '0;
            gain_ff[i] <= mlal_pkg::UNITY_GAIN;
            mute_ff[i] <= 1'b0;
         end
         loop_len_ff <= '0;
         pos_ff      <= '0;
         run_ff      <= mlal_pkg::RUN_IDLE;
         total_ff    <= '0;
         active_ff   <= mlal_pkg::NO_LAYER;
         peak_ff     <= '0;
         s1_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
      end else begin
         len_ff      <= len_in;
         ext_ff      <= ext_in;
         gain_ff     <= gain_in;
         mute_ff     <= mute_in;
         loop_len_ff <= loop_len_in;
         pos_ff      <= pos_in;
         run_ff      <= run_in;
         total_ff    <= total_in;
         active_ff   <= active_in;
         peak_ff     <= peak_in;
         s1_valid_ff <= cmd.issue && incl;
         p_valid_ff  <= s1_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mlal_pkg::mode_type'(req_mode);
         smp_ff  <= req_sample_in;
         sel_ff  <= req_layer_sel;
         gval_ff <= req_gain_value;
         mval_ff <= req_mute_value;
      end
      s1_gain_ff <= gain_ff[mix_idx];
      p_ff       <= rd_data * $signed({1'b0, s1_gain_ff});
      acc_ff     <= acc_in;
      if (cmd.commit_smp || cmd.commit_cmd) begin
         rsp_smp_ff    <= cmd.commit_smp ? y : '0;
         rsp_peak_ff   <= peak_in;
         rsp_mode_ff   <= run_in;
         rsp_layers_ff <= 3'(total_in);
      end
   end

   assign rsp_sample_out  = rsp_smp_ff;
   assign rsp_peak_out    = rsp_peak_ff;
   assign rsp_looper_mode = rsp_mode_ff;
   assign rsp_layers_used = rsp_layers_ff;

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      total4 <= 4'(MAX_LAYERS))
      else $error("layer count beyond capacity");

   a_rec_has_layer: assert property (@(posedge clock) disable iff (reset)
      (run_ff == mlal_pkg::RUN_REC || run_ff == mlal_pkg::RUN_OVD)
      |-> (act4 < total4))
      else $error("recording without an open layer");

   a_no_layers_idle: assert property (@(posedge clock) disable iff (reset)
      (total_ff == '0) |-> (run_ff == mlal_pkg::RUN_IDLE || run_ff == mlal_pkg::RUN_PLAY))
      else $error("writing with no layers held");

endmodule

// File: rtl/core/multi_layer_audio_looper_core.sv
// ---------------------------------------------------------------------------
// multi_layer_audio_looper_core: layered loop recorder with overdub
// Samples are passed through and mixed with the unmuted layers; commands
// record, stop, overdub, undo and set layer gain or mute.
// ---------------------------------------------------------------------------
//  channel   direction  ports                                   handshake
//  req       in         mode, sample_in, layer_sel, gain/mute   req_valid/req_ready
//  rsp       out        sample_out, peak_out, looper_mode,      rsp_valid/rsp_ready
//                       layers_used
//
//  A sample passes through the accept step, one read of the sample store per
//  layer through a single read port, the multiply and accumulate stages and
//  the commit step; a command passes through the accept and commit steps.
//  Each result is registered into the response register at its commit step.
//  One item is in work at a time; the next item is accepted while the
//  previous result waits in the response register.
//  A result waiting on rsp_ready holds the next item at its commit step.
//  Synchronous reset; the sample store needs no clearing after reset.
// ---------------------------------------------------------------------------
module multi_layer_audio_looper_core #(
   parameter int MAX_LAYERS = mlal_pkg::DEF_MAX_LAYERS,
   parameter int MAX_FRAMES = mlal_pkg::DEF_MAX_FRAMES
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [mlal_pkg::MODE_W-1:0]              req_mode,
   input  logic signed [mlal_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   input  logic [mlal_pkg::SEL_W-1:0]               req_layer_sel,
   input  logic [mlal_pkg::GAIN_W-1:0]              req_gain_value,
   input  logic                                     req_mute_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [mlal_pkg::SAMPLE_BITS-1:0]  rsp_sample_out,
   output logic [mlal_pkg::SAMPLE_BITS-1:0]         rsp_peak_out,
   output logic [1:0]                               rsp_looper_mode,
   output logic [2:0]                               rsp_layers_used
);

   localparam int LB = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

   mlal_pkg::dp_cmd_type cmd;
   logic [LB-1:0]        mix_idx;

   mlal_ctrl #(
      .MAX_LAYERS (MAX_LAYERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .mix_idx   (mix_idx)
   );

   mlal_dp #(
      .MAX_LAYERS (MAX_LAYERS),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .mix_idx         (mix_idx),
      .req_mode        (req_mode),
      .req_sample_in   (req_sample_in),
      .req_layer_sel   (req_layer_sel),
      .req_gain_value  (req_gain_value),
      .req_mute_value  (req_mute_value),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_peak_out    (rsp_peak_out),
      .rsp_looper_mode (rsp_looper_mode),
      .rsp_layers_used (rsp_layers_used)
   );

endmodule

// File: dv/looper_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// looper_checker: mix predictor and response scoreboard
// Watches the request and response channels, runs its own copy of the
// layered looper state for every accepted request, and compares each
// accepted response with the oldest predicted one, field by field.
// ---------------------------------------------------------------------------
module looper_checker #(
   parameter int MAX_LAYERS = mlal_pkg::DEF_MAX_LAYERS,
   parameter int MAX_FRAMES = mlal_pkg::DEF_MAX_FRAMES
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic [mlal_pkg::MODE_W-1:0]             req_mode,
   input  logic signed [mlal_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic [mlal_pkg::SEL_W-1:0]              req_layer_sel,
   input  logic [mlal_pkg::GAIN_W-1:0]             req_gain_value,
   input  logic                                    req_mute_value,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [mlal_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic [mlal_pkg::SAMPLE_BITS-1:0]        rsp_peak_out,
   input  logic [1:0]                              rsp_looper_mode,
   input  logic [2:0]                              rsp_layers_used,
   output int                                      fail_count,
   output int                                      pending_count
);

   localparam int SB = mlal_pkg::SAMPLE_BITS;

   typedef struct packed {
      logic signed [SB-1:0] mixed;
      logic [SB-1:0]        peak;
      logic [1:0]           state;
      logic [2:0]           layers;
   } mix_result_type;

   mix_result_type mix_queue[$];

   logic signed [SB-1:0] layer_mem [MAX_LAYERS][MAX_FRAMES];
   int unsigned    lay_len   [MAX_LAYERS];
   int unsigned    lay_extent[MAX_LAYERS];
   int unsigned    lay_gain  [MAX_LAYERS];
   bit             lay_mute  [MAX_LAYERS];
   int unsigned    loop_frames, frame_idx, lay_count, active_lay;
   mlal_pkg::run_type looper_state;
   longint         peak_hold;

   task automatic clear_looper();
      for (int i = 0; i < MAX_LAYERS; i++) begin
         lay_len[i] = 0; lay_extent[i] = 0; lay_gain[i] = mlal_pkg::UNITY_GAIN;
         lay_mute[i] = 0;
      end
      loop_frames = 0; frame_idx = 0; lay_count = 0;
      active_lay = mlal_pkg::NO_LAYER; looper_state = mlal_pkg::RUN_IDLE; peak_hold = 0;
   endtask

   task automatic open_layer(int unsigned len);
      lay_len[lay_count] = len; lay_extent[lay_count] = 0;
      lay_gain[lay_count] = mlal_pkg::UNITY_GAIN; lay_mute[lay_count] = 0;
      active_lay = lay_count; lay_count++; frame_idx = 0;
   endtask

   task automatic store_live(longint x);
      if (active_lay >= MAX_LAYERS || frame_idx >= MAX_FRAMES) return;
      layer_mem[active_lay][frame_idx] = SB'(x);
      if (frame_idx + 1 > lay_extent[active_lay]) lay_extent[active_lay] = frame_idx + 1;
   endtask

   function automatic longint sum_layers(int unsigned limit, int unsigned skip);
      longint acc;
      acc = 0;
      if (limit > MAX_LAYERS) limit = MAX_LAYERS;
      for (int unsigned i = 0; i < limit; i++) begin
         if (i == skip || lay_mute[i]) continue;
         if (frame_idx < lay_len[i] && frame_idx < lay_extent[i] && frame_idx < MAX_FRAMES)
            acc += longint'(layer_mem[i][frame_idx]) * longint'(lay_gain[i]);
      end
      return acc;
   endfunction

   task automatic step_loop();
      if (loop_frames > 0) begin
         frame_idx++;
         if (frame_idx >= loop_frames) frame_idx = 0;
      end else if (frame_idx < MAX_FRAMES) begin
         frame_idx++;
      end
   endtask

   task automatic mix_sample(longint x, output longint y);
      longint acc, a, hi, mag;
      acc = x * longint'(mlal_pkg::UNITY_GAIN);
      case (looper_state)
         mlal_pkg::RUN_REC: begin
            store_live(x);
            acc += sum_layers(active_lay, mlal_pkg::NO_LAYER + 1);
            if (frame_idx < MAX_FRAMES) frame_idx++;
         end
         mlal_pkg::RUN_PLAY: begin
            acc += sum_layers(lay_count, mlal_pkg::NO_LAYER + 1);
            step_loop();
         end
         mlal_pkg::RUN_OVD: begin
            if (frame_idx < loop_frames) store_live(x);
            acc += sum_layers(lay_count, active_lay);
            step_loop();
         end
         default: ;
      endcase
      a = acc + mlal_pkg::ROUND_BIAS;
      y = (a >= 0) ? a / 16384 : -((-a + 16383) / 16384);
      hi = (longint'(1) << (SB - 1)) - 1;
      if (y > hi) y = hi;
      if (y < -hi - 1) y = -hi - 1;
      mag = (y < 0) ? -y : y;
      if (mag > peak_hold) peak_hold = mag;
   endtask

   task automatic predict_item();
      longint y;
      mix_result_type r;
      y = 0;
      case (mlal_pkg::mode_type'(req_mode))
         mlal_pkg::MODE_SAMPLE: mix_sample(longint'(req_sample_in), y);
         mlal_pkg::MODE_RECORD: if (lay_count < MAX_LAYERS) begin
            open_layer(0); looper_state = mlal_pkg::RUN_REC;
         end
         mlal_pkg::MODE_STOP: begin
            if (looper_state == mlal_pkg::RUN_REC && active_lay < MAX_LAYERS) begin
               lay_len[active_lay] = frame_idx;
               if (loop_frames == 0) loop_frames = frame_idx;
               looper_state = mlal_pkg::RUN_PLAY; frame_idx = 0;
            end else if (looper_state == mlal_pkg::RUN_OVD) looper_state = mlal_pkg::RUN_PLAY;
            else looper_state = mlal_pkg::RUN_IDLE;
         end
         mlal_pkg::MODE_OVERDUB: if (lay_count < MAX_LAYERS && loop_frames != 0) begin
            open_layer(loop_frames); looper_state = mlal_pkg::RUN_OVD;
         end
         mlal_pkg::MODE_UNDO: if (lay_count > 0) begin
            lay_count--; frame_idx = 0;
            if (lay_count == 0) begin
               looper_state = mlal_pkg::RUN_IDLE; loop_frames = 0;
            end else looper_state = mlal_pkg::RUN_PLAY;
         end
         mlal_pkg::MODE_GAIN:
            if (req_layer_sel < lay_count) lay_gain[req_layer_sel] = req_gain_value;
         mlal_pkg::MODE_MUTE:
            if (req_layer_sel < lay_count) lay_mute[req_layer_sel] = req_mute_value;
         default: ;
      endcase
      r.mixed  = SB'(y);
      r.peak   = SB'(peak_hold);
      r.state  = looper_state;
      r.layers = 3'(lay_count);
      mix_queue.push_back(r);
   endtask

   task automatic compare_response();
      mix_result_type e;
      if (mix_queue.size() == 0) begin
         $display("%0t: response with none expected", $time);
         fail_count++;
         return;
      end
      e = mix_queue.pop_front();
      if (rsp_sample_out !== e.mixed) begin
         $display("%0t: sample_out exp %0d got %0d", $time, e.mixed, rsp_sample_out);
         fail_count++;
      end
      if (rsp_peak_out !== e.peak) begin
         $display("%0t: peak_out exp %0d got %0d", $time, e.peak, rsp_peak_out);
         fail_count++;
      end
      if (rsp_looper_mode !== e.state) begin
         $display("%0t: looper_mode exp %0d got %0d", $time, e.state, rsp_looper_mode);
         fail_count++;
      end
      if (rsp_layers_used !== e.layers) begin
         $display("%0t: layers_used exp %0d got %0d", $time, e.layers, rsp_layers_used);
         fail_count++;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      clear_looper();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_looper();
         mix_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_response();
         if (req_valid && req_ready) predict_item();
      end
      pending_count = mix_queue.size();
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: layered loop recorder testbench
// Drives directed and random record/overdub/play sessions with random idle
// and stall phases; the checker predicts and scores every response.
// ---------------------------------------------------------------------------
module tb;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [mlal_pkg::MODE_W-1:0] req_mode = mlal_pkg::MODE_NOP;
   logic signed [mlal_pkg::SAMPLE_BITS-1:0] req_sample_in = '0;
   logic [mlal_pkg::SEL_W-1:0] req_layer_sel = '0;
   logic [mlal_pkg::GAIN_W-1:0] req_gain_value = '0;
   logic req_mute_value = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [mlal_pkg::SAMPLE_BITS-1:0] rsp_sample_out;
   logic [mlal_pkg::SAMPLE_BITS-1:0] rsp_peak_out;
   logic [1:0] rsp_looper_mode;
   logic [2:0] rsp_layers_used;
   int fail_count, pending_count;
   int send_idle_pct = 0, recv_stall_pct = 0;
   int sent_items = 0;

   always #2 clock = ~clock;

   multi_layer_audio_looper_core i_dut (.*);
   looper_checker i_checker (.*);

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // valid stays high into the next transaction unless an idle gap is drawn
   task automatic send_item(mlal_pkg::mode_type m,
                            logic signed [mlal_pkg::SAMPLE_BITS-1:0] s,
                            logic [mlal_pkg::SEL_W-1:0] sel,
                            logic [mlal_pkg::GAIN_W-1:0] g, logic mu);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1; req_mode <= m; req_sample_in <= s;
      req_layer_sel <= sel; req_gain_value <= g; req_mute_value <= mu;
      sent_items++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_samples(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: send_item(mlal_pkg::MODE_SAMPLE, 24'sh7FFFFF, 0, 0, 0);
            1: send_item(mlal_pkg::MODE_SAMPLE, 24'sh800000, 0, 0, 0);
            default: send_item(mlal_pkg::MODE_SAMPLE, 24'($urandom), 3'($urandom),
                               16'($urandom), 1'($urandom));
         endcase
      end
   endtask

   task automatic random_command();
      mlal_pkg::mode_type m;
      m = mlal_pkg::mode_type'($urandom_range(7));
      send_item(m, 24'($urandom), 3'($urandom), 16'($urandom), 1'($urandom));
   endtask

   // one session: record a loop, overdub and tweak layers, play, then maybe undo
   task automatic session();
      send_item(mlal_pkg::MODE_RECORD, 0, 0, 0, 0);
      send_samples($urandom_range(1, 12));
      send_item(mlal_pkg::MODE_STOP, 0, 0, 0, 0);
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(5))
            0, 1: begin
               send_item(mlal_pkg::MODE_OVERDUB, 0, 0, 0, 0);
               send_samples($urandom_range(1, 20));
               send_item(mlal_pkg::MODE_STOP, 0, 0, 0, 0);
            end
            2: send_item(mlal_pkg::MODE_GAIN, 0, 3'($urandom_range(4)), 16'($urandom), 0);
            3: send_item(mlal_pkg::MODE_MUTE, 0, 3'($urandom_range(4)), 0, 1'($urandom));
            4: send_item(mlal_pkg::MODE_UNDO, 0, 0, 0, 0);
            default: random_command();
         endcase
         send_samples($urandom_range(1, 10));
      end
      if ($urandom_range(3) == 0) random_command();
      if ($urandom_range(1)) repeat (5) send_item(mlal_pkg::MODE_UNDO, 0, 0, 0, 0);
   endtask

   initial begin
      int phase_start;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, every command, ignored and saturating cases
      send_item(mlal_pkg::MODE_UNDO, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_STOP, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_OVERDUB, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_GAIN, 0, 0, 16'hFFFF, 0);
      send_item(mlal_pkg::MODE_SAMPLE, 24'sh7FFFFF, 0, 0, 0);
      send_item(mlal_pkg::MODE_SAMPLE, 24'sh800000, 7, 16'hFFFF, 1);
      send_item(mlal_pkg::MODE_RECORD, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_SAMPLE, 24'sh7FFFFF, 0, 0, 0);
      send_item(mlal_pkg::MODE_SAMPLE, 24'sh800000, 0, 0, 0);
      send_item(mlal_pkg::MODE_SAMPLE, 24'sh000001, 0, 0, 0);
      send_item(mlal_pkg::MODE_STOP, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_GAIN, 0, 0, 16'hFFFF, 0);
      send_item(mlal_pkg::MODE_OVERDUB, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_SAMPLE, 24'sh7FFFFF, 0, 0, 0);
      send_item(mlal_pkg::MODE_SAMPLE, 24'sh800000, 0, 0, 0);
      send_item(mlal_pkg::MODE_STOP, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_RECORD, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_RECORD, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_RECORD, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_MUTE, 0, 1, 0, 1);
      send_item(mlal_pkg::MODE_MUTE, 0, 4, 0, 1);
      send_item(mlal_pkg::MODE_NOP, 0, 0, 0, 0);
      send_item(mlal_pkg::MODE_SAMPLE, 24'sh400000, 0, 0, 0);
      repeat (4) send_item(mlal_pkg::MODE_UNDO, 0, 0, 0, 0);
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         phase_start = sent_items;
         while (sent_items - phase_start < 225) session();
         // hold off until every expected response has drained
         req_valid <= 0;
         while (pending_count != 0) @(negedge clock);
         @(negedge clock);
      end
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/mlal_pkg.sv
rtl/core/mlal_ram.sv
rtl/core/mlal_ctrl.sv
rtl/core/mlal_dp.sv
rtl/core/multi_layer_audio_looper_core.sv
dv/looper_checker.sv
dv/tb.sv
